// ===== sv/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants for the BER TLV element decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package btlv_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_SEPTETS_DEF = 9;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  // result queue depth (one byte can produce two results)
  localparam int unsigned RES_DEPTH = 4;

  // element selection on the identifier byte
  localparam logic [1:0] FUNC_INTEGER = 2'd0;
  localparam logic [1:0] FUNC_OID     = 2'd1;
  localparam logic [1:0] FUNC_OCTETS  = 2'd2;
  localparam logic [1:0] FUNC_GENERIC = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_INT    = 2'd1;
  localparam logic [1:0] KIND_ARC    = 2'd2;

  // universal tag numbers of the fixed element types
  localparam logic [31:0] TAG_INTEGER = 32'd2;
  localparam logic [31:0] TAG_OCTETS  = 32'd4;
  localparam logic [31:0] TAG_OID     = 32'd6;

  localparam logic [4:0] TAG_HIGH_FORM  = 5'h1F;
  localparam logic [7:0] LEN_LONG_FIRST = 8'h81;
  localparam int unsigned OID_ARC_BASE  = 40;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         tag_class;
    logic               constructed;
    logic [31:0]        tag_number;
    logic               mismatch;
    logic [31:0]        content_length;
    logic signed [31:0] int_value;
    logic [31:0]        arc_value;
    logic               last;
  } btlv_result_t;

endpackage

`default_nettype wire

// ===== sv/btlv_parser.sv =====
// ----------------------------------------------------------------------------
// btlv_parser
// Byte-wide TLV parser: holds the decode state and turns each accepted byte
// into zero, one or two result records.
// ----------------------------------------------------------------------------
`default_nettype none

module btlv_parser #(
  parameter int unsigned MAX_SEPTETS = 9,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic [1:0]            func,
  input  wire logic [1:0]            expected_class,
  input  wire logic                  expected_constructed,
  input  wire logic [31:0]           expected_tag,
  output logic [1:0]                 res_count,
  output btlv_pkg::btlv_result_t     res_a,
  output btlv_pkg::btlv_result_t     res_b
);
  import btlv_pkg::*;

  localparam int unsigned SC_W  = $clog2(MAX_SEPTETS + 1);
  localparam int unsigned CMP_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TAGHI   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_LENLONG = 3'd3;
  localparam logic [2:0] PH_INT     = 3'd4;
  localparam logic [2:0] PH_OID     = 3'd5;

  logic [2:0]            phase, phase_next;
  logic [1:0]            element_kind, element_kind_next;
  logic [1:0]            want_class, want_class_next;
  logic                  want_constructed, want_constructed_next;
  logic [31:0]           want_tag, want_tag_next;
  logic [1:0]            got_class, got_class_next;
  logic                  got_constructed, got_constructed_next;
  logic [VALUE_BITS-1:0] accumulator, accumulator_next;
  logic [SC_W-1:0]       septet_count, septet_count_next;
  logic [31:0]           remaining_count, remaining_count_next;
  logic [31:0]           length_value, length_value_next;
  logic [31:0]           consumed_count, consumed_count_next;
  logic                  first_subid, first_subid_next;

  logic [VALUE_BITS-1:0] acc_sh7, acc_sh8, acc_sext;
  logic [SC_W-1:0]       sc_inc;
  logic [31:0]           rem_dec, cons_inc, len_shift;
  logic                  hdr_fire, done, subid_end;
  logic [31:0]           hdr_len;

  assign acc_sh7  = {accumulator[VALUE_BITS-8:0], data_byte[6:0]};
  assign acc_sh8  = {accumulator[VALUE_BITS-9:0], data_byte};
  assign acc_sext = {{(VALUE_BITS-8){data_byte[7]}}, data_byte};
  assign sc_inc   = septet_count + SC_W'(1);
  assign rem_dec  = remaining_count - 32'd1;
  // saturate the consumed count
  assign cons_inc = (consumed_count == '1) ? consumed_count : consumed_count + 32'd1;
  assign len_shift = {length_value[23:0], data_byte};
  assign subid_end = (sc_inc >= SC_W'(MAX_SEPTETS)) || !data_byte[7];
  assign done      = cons_inc >= length_value;

  always_comb begin
    phase_next            = phase;
    element_kind_next     = element_kind;
    want_class_next       = want_class;
    want_constructed_next = want_constructed;
    want_tag_next         = want_tag;
    got_class_next        = got_class;
    got_constructed_next  = got_constructed;
    accumulator_next      = accumulator;
    septet_count_next     = septet_count;
    remaining_count_next  = remaining_count;
    length_value_next     = length_value;
    consumed_count_next   = consumed_count;
    first_subid_next      = first_subid;
    hdr_fire              = 1'b0;
    hdr_len               = 32'd0;
    res_count             = 2'd0;
    res_a                 = '0;
    res_b                 = '0;

    unique case (phase)
      PH_IDLE: begin
        element_kind_next     = func;
        want_class_next       = 2'd0;
        want_constructed_next = 1'b0;
        unique case (func)
          FUNC_INTEGER: want_tag_next = TAG_INTEGER;
          FUNC_OID:     want_tag_next = TAG_OID;
          FUNC_OCTETS:  want_tag_next = TAG_OCTETS;
          default: begin
            want_class_next       = expected_class;
            want_constructed_next = expected_constructed;
            want_tag_next         = expected_tag;
          end
        endcase
        got_class_next       = data_byte[7:6];
        got_constructed_next = data_byte[5];
        if (data_byte[4:0] != TAG_HIGH_FORM) begin
          accumulator_next = VALUE_BITS'(data_byte[4:0]);
          phase_next       = PH_LEN;
        end else begin
          accumulator_next  = '0;
          septet_count_next = '0;
          phase_next        = PH_TAGHI;
        end
      end
      PH_TAGHI: begin
        accumulator_next  = acc_sh7;
        septet_count_next = sc_inc;
        if (subid_end) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (data_byte >= LEN_LONG_FIRST) begin
          remaining_count_next = 32'(data_byte[6:0]);
          length_value_next    = 32'd0;
          phase_next           = PH_LENLONG;
        end else begin
          hdr_fire = 1'b1;
          hdr_len  = 32'(data_byte);
        end
      end
      PH_LENLONG: begin
        remaining_count_next = rem_dec;
        length_value_next    = len_shift;
        if (rem_dec == 32'd0) begin
          hdr_fire = 1'b1;
          hdr_len  = len_shift;
        end
      end
      PH_INT: begin
        accumulator_next     = (consumed_count == 32'd0) ? acc_sext : acc_sh8;
        consumed_count_next  = 32'd1;
        remaining_count_next = rem_dec;
        if (rem_dec == 32'd0) begin
          res_count           = 2'd1;
          res_a.kind          = KIND_INT;
          res_a.int_value     = 32'(accumulator_next);
          res_a.last          = 1'b1;
          accumulator_next    = '0;
          consumed_count_next = 32'd0;
          phase_next          = PH_IDLE;
        end
      end
      PH_OID: begin
        consumed_count_next = cons_inc;
        accumulator_next    = acc_sh7;
        septet_count_next   = sc_inc;
        if (subid_end) begin
          if (first_subid) begin
            res_count   = 2'd2;
            res_a.kind  = KIND_ARC;
            res_b.kind  = KIND_ARC;
            res_b.last  = done;
            // first subidentifier carries two arcs
            if (acc_sh7 < VALUE_BITS'(2 * OID_ARC_BASE)) begin
              if (acc_sh7 >= VALUE_BITS'(OID_ARC_BASE)) begin
                res_a.arc_value = 32'd1;
                res_b.arc_value = 32'(acc_sh7 - VALUE_BITS'(OID_ARC_BASE));
              end else begin
                res_a.arc_value = 32'd0;
                res_b.arc_value = 32'(acc_sh7);
              end
            end else begin
              res_a.arc_value = 32'd2;
              res_b.arc_value = 32'(acc_sh7 - VALUE_BITS'(2 * OID_ARC_BASE));
            end
          end else begin
            res_count       = 2'd1;
            res_a.kind      = KIND_ARC;
            res_a.arc_value = 32'(acc_sh7);
            res_a.last      = done;
          end
          first_subid_next  = 1'b0;
          accumulator_next  = '0;
          septet_count_next = '0;
          if (done) begin
            consumed_count_next = 32'd0;
            first_subid_next    = 1'b1;
            phase_next          = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    // close the header: emit it and pick the content handling
    if (hdr_fire) begin
      length_value_next    = hdr_len;
      res_count            = 2'd1;
      res_a.kind           = KIND_HEADER;
      res_a.tag_class      = got_class;
      res_a.constructed    = got_constructed;
      res_a.tag_number     = 32'(accumulator);
      res_a.mismatch       = (got_class != want_class) ||
                             (CMP_W'(accumulator) != CMP_W'(want_tag)) ||
                             (got_constructed != want_constructed);
      res_a.content_length = hdr_len;
      res_a.last           = element_kind[1];
      accumulator_next     = '0;
      septet_count_next    = '0;
      consumed_count_next  = 32'd0;
      if (element_kind == FUNC_INTEGER) begin
        remaining_count_next = (hdr_len != 32'd0) ? hdr_len : 32'd1;
        phase_next           = PH_INT;
      end else if (element_kind == FUNC_OID) begin
        first_subid_next = 1'b1;
        phase_next       = PH_OID;
      end else begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      element_kind     <= 2'd0;
      want_class       <= 2'd0;
      want_constructed <= 1'b0;
      want_tag         <= 32'd0;
      got_class        <= 2'd0;
      got_constructed  <= 1'b0;
      accumulator      <= '0;
      septet_count     <= '0;
      remaining_count  <= 32'd0;
      length_value     <= 32'd0;
      consumed_count   <= 32'd0;
      first_subid      <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      element_kind     <= element_kind_next;
      want_class       <= want_class_next;
      want_constructed <= want_constructed_next;
      want_tag         <= want_tag_next;
      got_class        <= got_class_next;
      got_constructed  <= got_constructed_next;
      accumulator      <= accumulator_next;
      septet_count     <= septet_count_next;
      remaining_count  <= remaining_count_next;
      length_value     <= length_value_next;
      consumed_count   <= consumed_count_next;
      first_subid      <= first_subid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/btlv_res_fifo.sv =====
// ----------------------------------------------------------------------------
// btlv_res_fifo
// Small result queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module btlv_res_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [1:0]               push_count,
  input  wire btlv_pkg::btlv_result_t   push_a,
  input  wire btlv_pkg::btlv_result_t   push_b,
  input  wire logic                     pop,
  output btlv_pkg::btlv_result_t        head,
  output logic [$clog2(DEPTH+1)-1:0]    level
);
  import btlv_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  btlv_result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_p1;
  logic [LVL_W-1:0] level_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_p1  = ptr_inc(wr_ptr);
  assign head       = entries[rd_ptr];
  assign level_next = level + LVL_W'(push_count) - LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push_a;
    if (push_count == 2'd2) entries[wr_ptr_p1] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_count == 2'd1) wr_ptr <= wr_ptr_p1;
      else if (push_count == 2'd2) wr_ptr <= ptr_inc(wr_ptr_p1);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ber_tlv_element_decoder_core.sv =====
// Output: each result is written into the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle; the first OID subidentifier yields two results,
// which the queue absorbs, so input stalls only when out_stall backs the queue up.
// Queue: four entries; input stalls when fewer than two are free.
// Reset: synchronous, active high; returns to awaiting an identifier and empties
// the result queue.
// ----------------------------------------------------------------------------
// ber_tlv_element_decoder_core
// BER TLV element decoder: identifier, length, INTEGER value and OID arcs.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_tlv_element_decoder_core #(
  parameter int unsigned MAX_SEPTETS = btlv_pkg::MAX_SEPTETS_DEF,
  parameter int unsigned VALUE_BITS  = btlv_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic [1:0]         func,
  input  wire logic [1:0]         expected_class,
  input  wire logic               expected_constructed,
  input  wire logic [31:0]        expected_tag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [1:0]              tag_class,
  output logic                    constructed,
  output logic [31:0]             tag_number,
  output logic                    mismatch,
  output logic [31:0]             content_length,
  output logic signed [31:0]      int_value,
  output logic [31:0]             arc_value,
  output logic                    last
);
  import btlv_pkg::*;

  localparam int unsigned LVL_W = $clog2(RES_DEPTH + 1);

  logic             in_accept, out_accept;
  logic [1:0]       res_count, push_count;
  btlv_result_t     res_a, res_b, head;
  logic [LVL_W-1:0] level;

  // hold off requests unless two queue slots are free
  assign in_stall   = level > LVL_W'(RES_DEPTH - 2);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = level != '0;
  assign out_accept = out_valid && !out_stall;
  assign push_count = in_accept ? res_count : 2'd0;

  btlv_parser #(
    .MAX_SEPTETS (MAX_SEPTETS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (in_accept),
    .data_byte            (data_byte),
    .func                 (func),
    .expected_class       (expected_class),
    .expected_constructed (expected_constructed),
    .expected_tag         (expected_tag),
    .res_count            (res_count),
    .res_a                (res_a),
    .res_b                (res_b)
  );

  btlv_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_a     (res_a),
    .push_b     (res_b),
    .pop        (out_accept),
    .head       (head),
    .level      (level)
  );

  assign kind           = head.kind;
  assign tag_class      = head.tag_class;
  assign constructed    = head.constructed;
  assign tag_number     = head.tag_number;
  assign mismatch       = head.mismatch;
  assign content_length = head.content_length;
  assign int_value      = head.int_value;
  assign arc_value      = head.arc_value;
  assign last           = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(RES_DEPTH))
    else $error("result queue overfilled");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    !out_accept |=> level == $past(level) + LVL_W'($past(push_count)))
    else $error("result queue level lost track of pushes");

  a_pair_only_on_oid: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd2 |-> (res_a.kind == KIND_ARC && res_b.kind == KIND_ARC))
    else $error("two results from one byte that are not OID arcs");

  a_stall_room: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> level <= LVL_W'(RES_DEPTH - 2))
    else $error("request taken without room for two results");

endmodule

`default_nettype wire
